[design/hci_packet_reassembler_macros.svh]
// assertion macros for the hci packet reassembler
// used by the top level only, no other dependencies
`ifndef HCI_PACKET_REASSEMBLER_MACROS_SVH
`define HCI_PACKET_REASSEMBLER_MACROS_SVH
`ifndef SYNTHESIS
`define HPR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("hpr assertion failed");
`define HPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hpr assertion failed");
`else
`define HPR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/hpr_pkg.sv]
// types and constants shared by the hci packet reassembler modules
// no dependencies
`default_nettype none
package hpr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHUNK_W = 11;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned HPOS_W  = 2;

	localparam logic CH_EVENT = 1'b0;
	localparam logic CH_ACL   = 1'b1;

	localparam logic [CHUNK_W-1:0] EVT_HDR_LEN = 11'd2;
	localparam logic [CHUNK_W-1:0] ACL_HDR_LEN = 11'd4;

	localparam logic [HPOS_W-1:0] HPOS_FIRST  = 2'd1;
	localparam logic [HPOS_W-1:0] HPOS_LEN_LO = 2'd2;
	localparam logic [HPOS_W-1:0] HPOS_LEN_HI = 2'd3;
	localparam logic [HPOS_W-1:0] HPOS_NONE   = 2'd0;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_left;
		logic               req_type;
		logic [BYTE_W-1:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic              framing_error;
		logic              last_of_packet;
		logic              first_of_packet;
		logic              out_kind;
		logic [BYTE_W-1:0] out_byte;
	} result_t;

endpackage
`default_nettype wire

[design/hci_packet_reassembler.sv]
// top level of the hci packet reassembler: input register, framing core, result register
// depends on hpr_pkg, hpr_in_stage, hpr_core, hpr_out_stage and the macros header
//
// Reassembles HCI event and ACL packets from USB transfer bytes on two independent
// channels, passing every packet byte on with first and last marks, and giving one
// framing error item when a packet would start with fewer transfer bytes left than its
// header needs; the rest of that transfer is then dropped without results. One byte is
// taken every cycle while the result side keeps up; a byte goes from the input register
// through the per-channel state update to the result register, and its result is held
// there until the output side takes it. Dropped bytes give no result.
`default_nettype none
`include "hci_packet_reassembler_macros.svh"
module hci_packet_reassembler (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,  // data_byte[7:0], chunk_left[18:8], zero pad
	input  wire         s_tuser,  // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,  // out_byte
	output logic        m_tlast,
	output logic [2:0]  m_tuser   // out_kind, first_of_packet, framing_error
);

	hpr_pkg::in_item_t in_item;
	hpr_pkg::in_item_t item;
	hpr_pkg::result_t  res;
	hpr_pkg::result_t  out_res;
	logic              item_valid;
	logic              space;
	logic              take;
	logic              res_valid;

	assign in_item.data_byte  = s_tdata[7:0];
	assign in_item.chunk_left = s_tdata[18:8];
	assign in_item.req_type   = s_tuser;
	assign take = item_valid && space;

	hpr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (take),
		.item       (item)
	);

	hpr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	hpr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.out_byte;
	assign m_tlast = out_res.last_of_packet;
	assign m_tuser = {out_res.framing_error, out_res.first_of_packet, out_res.out_kind};

	`HPR_ASSERT_SAME(a_err_clean, clk, arst_n, m_tvalid && m_tuser[2], m_tdata == 8'd0 && !m_tlast && !m_tuser[1])
	`HPR_ASSERT_SAME(a_first_not_last, clk, arst_n, m_tvalid && m_tuser[1], !m_tlast)
	`HPR_ASSERT_NEXT(a_result_lands, clk, arst_n, take && res_valid, m_tvalid)

endmodule
`default_nettype wire

[design/hpr_in_stage.sv]
// input register of the hci packet reassembler
// depends on hpr_pkg
`default_nettype none
module hpr_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  hpr_pkg::in_item_t   in_item,
	output logic                item_valid,
	input  wire                 item_take,
	output hpr_pkg::in_item_t   item
);

	logic              valid_s1;
	hpr_pkg::in_item_t item_s1;

	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

[design/hpr_core.sv]
// per channel framing state and decode of one byte
// depends on hpr_pkg
`default_nettype none
module hpr_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  hpr_pkg::in_item_t   item,
	output logic                res_valid,
	output hpr_pkg::result_t    res
);

	logic                             in_packet_q [2];
	logic [hpr_pkg::HPOS_W-1:0]       header_pos_q [2];
	logic [hpr_pkg::LEN_W-1:0]        bytes_rem_q [2];
	logic                             dropping_q [2];
	logic [hpr_pkg::BYTE_W-1:0]       len_low_q;

	logic                             ch;
	logic [hpr_pkg::CHUNK_W-1:0]      hdr_len;
	logic                             xfer_last;
	logic                             nxt_in;
	logic [hpr_pkg::HPOS_W-1:0]       nxt_pos;
	logic [hpr_pkg::LEN_W-1:0]        nxt_rem;
	logic                             nxt_drop;
	logic                             len_low_we;
	logic [hpr_pkg::LEN_W-1:0]        len;
	logic                             done;

	assign ch        = item.req_type;
	assign hdr_len   = (ch == hpr_pkg::CH_ACL) ? hpr_pkg::ACL_HDR_LEN : hpr_pkg::EVT_HDR_LEN;
	assign xfer_last = item.chunk_left <= 11'd1;

	always_comb begin
		nxt_in     = in_packet_q[ch];
		nxt_pos    = header_pos_q[ch];
		nxt_rem    = bytes_rem_q[ch];
		nxt_drop   = dropping_q[ch];
		len_low_we = 1'b0;
		len        = '0;
		done       = 1'b0;
		res_valid  = 1'b1;
		res        = '0;
		res.out_kind = ch;
		res.out_byte = item.data_byte;
		if (dropping_q[ch]) begin
			res_valid = 1'b0;
			if (xfer_last) begin
				nxt_drop = 1'b0;
			end
		end else if (!in_packet_q[ch]) begin
			if (item.chunk_left < hdr_len) begin
				nxt_drop          = !xfer_last;
				res.out_byte      = '0;
				res.framing_error = 1'b1;
			end else begin
				nxt_in              = 1'b1;
				nxt_pos             = hpr_pkg::HPOS_FIRST;
				nxt_rem             = '0;
				res.first_of_packet = 1'b1;
			end
		end else if (bytes_rem_q[ch] != '0) begin
			nxt_rem = bytes_rem_q[ch] - 16'd1;
			if (bytes_rem_q[ch] == 16'd1) begin
				nxt_in             = 1'b0;
				nxt_pos            = hpr_pkg::HPOS_NONE;
				res.last_of_packet = 1'b1;
			end
		end else begin
			if (ch == hpr_pkg::CH_EVENT) begin
				len  = {8'd0, item.data_byte};
				done = 1'b1;
			end else if (header_pos_q[ch] == hpr_pkg::HPOS_LEN_LO) begin
				len_low_we = 1'b1;
				nxt_pos    = hpr_pkg::HPOS_LEN_HI;
			end else if (header_pos_q[ch] == hpr_pkg::HPOS_LEN_HI) begin
				len  = {item.data_byte, len_low_q};
				done = 1'b1;
			end else begin
				nxt_pos = header_pos_q[ch] + 2'd1;
			end
			if (done) begin
				nxt_pos = hpr_pkg::HPOS_NONE;
				if (len == '0) begin
					nxt_in             = 1'b0;
					nxt_rem            = '0;
					res.last_of_packet = 1'b1;
				end else begin
					nxt_rem = len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				in_packet_q[i]  <= 1'b0;
				header_pos_q[i] <= hpr_pkg::HPOS_NONE;
				bytes_rem_q[i]  <= '0;
				dropping_q[i]   <= 1'b0;
			end
		end else if (take) begin
			in_packet_q[ch]  <= nxt_in;
			header_pos_q[ch] <= nxt_pos;
			bytes_rem_q[ch]  <= nxt_rem;
			dropping_q[ch]   <= nxt_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (take && len_low_we) begin
			len_low_q <= item.data_byte;
		end
	end

endmodule
`default_nettype wire

[design/hpr_out_stage.sv]
// result register of the hci packet reassembler
// depends on hpr_pkg
`default_nettype none
module hpr_out_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire                 res_valid,
	input  hpr_pkg::result_t    res,
	output logic                space,
	output logic                out_valid,
	input  wire                 out_ready,
	output hpr_pkg::result_t    out_res
);

	logic             valid_q;
	hpr_pkg::result_t res_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for hci_packet_reassembler: event and acl bytes on two channels
// predicts each result item in-bench and checks items in order; depends on hpr_pkg
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHUNK = 1024;
	localparam int RANDOM_RESULTS = 200;
	localparam int CHUNK_W = hpr_pkg::CHUNK_W;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	hci_packet_reassembler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb_top NOT OK");
		$finish;
	end

	// per-channel framing state
	logic                       pkt_open [2];
	logic [hpr_pkg::HPOS_W-1:0] hdr_idx [2];
	logic [16:0]                payload_left [2];
	logic                       skip_xfer [2];
	logic [7:0]                 acl_len_lo;

	hpr_pkg::result_t expected_bytes [$];
	int      results_made = 0;
	int      mismatches = 0;
	int      xfer_left [2];
	bit      s_burst = 1'b0;
	bit      m_burst = 1'b0;
	bit      took = 1'b0;
	int      hold = 0;

	function automatic void reassemble_byte(input logic [7:0] b, input logic ch,
			input logic [CHUNK_W-1:0] left_raw);
		int               left;
		int               hdr;
		int               len;
		bit               done;
		hpr_pkg::result_t r;
		left = int'(left_raw);
		if (left == 0)
			left = 1;
		if (left > MAX_CHUNK)
			left = MAX_CHUNK;
		hdr = (ch == hpr_pkg::CH_ACL) ? int'(hpr_pkg::ACL_HDR_LEN) :
			int'(hpr_pkg::EVT_HDR_LEN);
		done = 1'b0;
		len = 0;
		r = '0;
		r.out_kind = ch;
		if (skip_xfer[ch]) begin
			if (left <= 1)
				skip_xfer[ch] = 1'b0;
			return;
		end
		if (!pkt_open[ch]) begin
			if (left < hdr) begin
				if (left > 1)
					skip_xfer[ch] = 1'b1;
				r.framing_error = 1'b1;
			end else begin
				pkt_open[ch] = 1'b1;
				hdr_idx[ch] = hpr_pkg::HPOS_FIRST;
				payload_left[ch] = '0;
				r.out_byte = b;
				r.first_of_packet = 1'b1;
			end
		end else if (payload_left[ch] != 0) begin
			r.out_byte = b;
			payload_left[ch] = payload_left[ch] - 17'd1;
			if (payload_left[ch] == 0) begin
				pkt_open[ch] = 1'b0;
				hdr_idx[ch] = hpr_pkg::HPOS_NONE;
				r.last_of_packet = 1'b1;
			end
		end else begin
			r.out_byte = b;
			if (ch == hpr_pkg::CH_EVENT) begin
				len = int'(b);
				done = 1'b1;
			end else if (hdr_idx[ch] == hpr_pkg::HPOS_LEN_LO) begin
				acl_len_lo = b;
				hdr_idx[ch] = hpr_pkg::HPOS_LEN_HI;
			end else if (hdr_idx[ch] == hpr_pkg::HPOS_LEN_HI) begin
				len = int'({b, acl_len_lo});
				done = 1'b1;
			end else begin
				hdr_idx[ch] = hdr_idx[ch] + 2'd1;
			end
			if (done) begin
				if (len == 0) begin
					pkt_open[ch] = 1'b0;
					hdr_idx[ch] = hpr_pkg::HPOS_NONE;
					r.last_of_packet = 1'b1;
				end else begin
					hdr_idx[ch] = hpr_pkg::HPOS_NONE;
					payload_left[ch] = 17'(len);
				end
			end
		end
		expected_bytes.push_back(r);
		results_made++;
	endfunction

	// length bytes get sensible values so packets close inside the run
	function automatic logic [7:0] pick_byte(input logic ch);
		int r;
		if (pkt_open[ch] && payload_left[ch] == 0) begin
			if (ch == hpr_pkg::CH_ACL && hdr_idx[ch] == hpr_pkg::HPOS_LEN_HI)
				return 8'h00;
			if (ch == hpr_pkg::CH_EVENT || hdr_idx[ch] == hpr_pkg::HPOS_LEN_LO) begin
				r = $urandom_range(0, 29);
				if (r < 6)
					return 8'h00;
				if (r == 29)
					return 8'($urandom_range(13, 60));
				return 8'($urandom_range(1, 12));
			end
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input logic [7:0] b, input logic ch,
			input logic [CHUNK_W-1:0] left);
		int gap;
		gap = s_burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, left, b};
		s_tuser <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		reassemble_byte(b, ch, left);
		@(negedge clk);
	endtask

	task automatic send_stream(input logic [7:0] b, input logic ch);
		int r;
		if (xfer_left[ch] == 0) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				xfer_left[ch] = $urandom_range(1, 3);
			else if (r == 9)
				xfer_left[ch] = $urandom_range(25, 80);
			else
				xfer_left[ch] = $urandom_range(4, 24);
		end
		send_item(b, ch, CHUNK_W'(xfer_left[ch]));
		xfer_left[ch]--;
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		idle_input();
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_event_packets();
		send_item(8'h0E, hpr_pkg::CH_EVENT, 11'd2);
		send_item(8'h00, hpr_pkg::CH_EVENT, 11'd1);
		send_item(8'hFF, hpr_pkg::CH_EVENT, 11'd5);
		send_item(8'h02, hpr_pkg::CH_EVENT, 11'd4);
		send_item(8'hFF, hpr_pkg::CH_EVENT, 11'd3);
		send_item(8'h00, hpr_pkg::CH_EVENT, 11'd2);
		send_item(8'h5A, hpr_pkg::CH_EVENT, 11'd1);
	endtask

	task automatic test_acl_packets();
		send_item(8'h01, hpr_pkg::CH_ACL, 11'd4);
		send_item(8'h20, hpr_pkg::CH_ACL, 11'd3);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd2);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd1);
		send_item(8'hFF, hpr_pkg::CH_ACL, 11'd4);
		send_item(8'hFF, hpr_pkg::CH_ACL, 11'd3);
		send_item(8'h01, hpr_pkg::CH_ACL, 11'd2);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd1);
		send_item(8'hAB, hpr_pkg::CH_ACL, 11'd1);
	endtask

	task automatic test_framing_errors();
		send_item(8'h02, hpr_pkg::CH_ACL, 11'd3);
		send_item(8'h55, hpr_pkg::CH_ACL, 11'd2);
		send_item(8'h04, hpr_pkg::CH_EVENT, 11'd2047);
		send_item(8'hAA, hpr_pkg::CH_ACL, 11'd1);
		send_item(8'h00, hpr_pkg::CH_EVENT, 11'd1025);
		send_item(8'h33, hpr_pkg::CH_ACL, 11'd0);
		send_item(8'h44, hpr_pkg::CH_EVENT, 11'd0);
		send_item(8'h02, hpr_pkg::CH_ACL, 11'd1024);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd1023);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd1022);
		send_item(8'h00, hpr_pkg::CH_ACL, 11'd1021);
	endtask

	task automatic test_long_packets();
		int i;
		s_burst = 1'b1;
		xfer_left[hpr_pkg::CH_ACL] = 300;
		send_stream(8'h02, hpr_pkg::CH_ACL);
		send_stream(8'h20, hpr_pkg::CH_ACL);
		send_stream(8'h00, hpr_pkg::CH_ACL);
		send_stream(8'h01, hpr_pkg::CH_ACL);
		for (i = 0; i < 128; i++)
			send_stream(8'($urandom_range(0, 255)), hpr_pkg::CH_ACL);
		s_burst = 1'b0;
		for (i = 0; i < 128; i++)
			send_stream(8'($urandom_range(0, 255)), hpr_pkg::CH_ACL);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int    base;
		int    n;
		bit    paused;
		logic  ch;
		logic [7:0] b;
		base = results_made;
		n = 0;
		paused = 1'b0;
		while (results_made - base < RANDOM_RESULTS) begin
			if (n % 40 == 0) begin
				s_burst = ($urandom_range(0, 3) == 0);
				m_burst = ($urandom_range(0, 3) == 0);
			end
			if (!paused && results_made - base >= RANDOM_RESULTS / 2) begin
				paused = 1'b1;
				wait_drained();
			end
			ch = 1'($urandom_range(0, 1));
			b = pick_byte(ch);
			// occasional broken transfer count
			if ($urandom_range(0, 39) == 0) begin
				send_item(b, ch, CHUNK_W'($urandom_range(0, 2047)));
				if (xfer_left[ch] != 0)
					xfer_left[ch]--;
			end else begin
				send_stream(b, ch);
			end
			n++;
		end
	endtask

	always @(posedge clk) begin
		hpr_pkg::result_t got;
		hpr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			took = 1'b1;
			got = '0;
			got.out_byte = m_tdata;
			got.out_kind = m_tuser[0];
			got.first_of_packet = m_tuser[1];
			got.framing_error = m_tuser[2];
			got.last_of_packet = m_tlast;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item byte=%h kind=%b first=%b last=%b err=%b",
					$time, got.out_byte, got.out_kind, got.first_of_packet,
					got.last_of_packet, got.framing_error);
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch expected byte=%h kind=%b first=%b last=%b err=%b",
						$time, want.out_byte, want.out_kind, want.first_of_packet,
						want.last_of_packet, want.framing_error);
					$display("%0t:          actual   byte=%h kind=%b first=%b last=%b err=%b",
						$time, got.out_byte, got.out_kind, got.first_of_packet,
						got.last_of_packet, got.framing_error);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (took) begin
			hold = m_burst ? 0 : $urandom_range(0, 14);
			took = 1'b0;
		end
		if (hold != 0) begin
			m_tready <= 1'b0;
			hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int i;
		for (i = 0; i < 2; i++) begin
			pkt_open[i] = 1'b0;
			hdr_idx[i] = hpr_pkg::HPOS_NONE;
			payload_left[i] = '0;
			skip_xfer[i] = 1'b0;
			xfer_left[i] = 0;
		end
		acl_len_lo = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_event_packets();
		test_acl_packets();
		test_framing_errors();
		wait_drained();
		test_long_packets();
		test_random_traffic();
		wait_drained();
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
+incdir+design
design/hpr_pkg.sv
design/hpr_in_stage.sv
design/hpr_core.sv
design/hpr_out_stage.sv
design/hci_packet_reassembler.sv
bench/tb_top.sv
